// ===== rtl/atci_pkg.sv =====
// ----------------------------------------------------------------------------
// atci_pkg
// Shared types and constants for the ATA task-file command issue block.
// ----------------------------------------------------------------------------
package atci_pkg;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_GEOM   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PRESENT = 2'd0;
    localparam logic [1:0] CFG_LBA     = 2'd1;
    localparam logic [1:0] CFG_HEADS   = 2'd2;
    localparam logic [1:0] CFG_SECTORS = 2'd3;

    localparam int CFG_DATA_W = 24;

    // port bases and register offsets
    localparam logic [9:0] BASE_PRI = 10'h1F0;
    localparam logic [9:0] BASE_SEC = 10'h170;
    localparam logic [9:0] OFS_FEAT = 10'd1;
    localparam logic [9:0] OFS_CNT  = 10'd2;
    localparam logic [9:0] OFS_B3   = 10'd3;
    localparam logic [9:0] OFS_B4   = 10'd4;
    localparam logic [9:0] OFS_B5   = 10'd5;
    localparam logic [9:0] OFS_DH   = 10'd6;
    localparam logic [9:0] OFS_CMD  = 10'd7;

    // task-file byte constants
    localparam logic [7:0] DH_FIXED  = 8'hA0;
    localparam logic [7:0] DH_LBA    = 8'h40;
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;

    // configuration registers as seen by the front end
    typedef struct packed {
        logic [3:0]  present;
        logic [3:0]  lba_mode;
        logic [19:0] heads;
        logic [23:0] sectors;
    } atci_cfg_t;

    // fully formatted command, passed from front end to back end
    typedef struct packed {
        logic [1:0] status;
        logic       chan;
        logic       op;
        logic [7:0] count;
        logic [7:0] dh;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
    } atci_cmd_t;

endpackage

// ===== rtl/atci_if.sv =====
// ----------------------------------------------------------------------------
// atci_req_if / atci_res_if
// Valid/ready channels for requests and task-file port writes.
// ----------------------------------------------------------------------------
interface atci_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [1:0]  channel;
    logic [1:0]  drive;
    logic [31:0] lba;
    logic [7:0]  count;

    modport source (output valid, op, channel, drive, lba, count, input ready);
    modport sink   (input valid, op, channel, drive, lba, count, output ready);
endinterface

interface atci_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] port;
    logic [7:0] value;
    logic       last;

    modport source (output valid, status, port, value, last, input ready);
    modport sink   (input valid, status, port, value, last, output ready);
endinterface

// ===== rtl/atci_front.sv =====
// ----------------------------------------------------------------------------
// atci_front
// Accepts requests, classifies them and builds the task-file bytes; CHS
// addresses go through a shared divider that retires four bits a cycle.
// ----------------------------------------------------------------------------
module atci_front #(
    parameter int CHANNELS = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  atci_pkg::atci_cfg_t cfg,
    atci_req_if.sink            req,
    output logic                q_push,
    output atci_pkg::atci_cmd_t q_data,
    input  logic                q_ready
);
    import atci_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV1, S_DIV2, S_PUSH} state_t;

    state_t      state_reg;
    atci_cmd_t   rec_reg;
    logic [31:0] quo_reg;
    logic [5:0]  rem_reg;
    logic [5:0]  dvs_reg;
    logic [4:0]  heads_reg;
    logic [2:0]  cnt_reg;

    logic        accept;
    logic [1:0]  dev;
    logic        bad;
    logic [4:0]  h_sel;
    logic [5:0]  s_sel;
    atci_cmd_t   ld_rec;
    state_t      ld_state;
    logic [31:0] quo_next;
    logic [5:0]  rem_next;

    // ready while idle or while the finished command leaves
    assign req.ready = (state_reg == S_IDLE) || (state_reg == S_PUSH && q_ready);
    assign accept    = req.valid && req.ready;
    assign q_push    = (state_reg == S_PUSH);
    assign q_data    = rec_reg;

    // request classification
    always_comb
    begin
        dev   = {req.channel[0], req.drive[0]};
        bad   = ({30'd0, req.channel} >= 32'(CHANNELS)) || (req.drive > 2'd1)
                || (req.count == 8'd0);
        h_sel = cfg.heads[5*dev +: 5];
        s_sel = cfg.sectors[6*dev +: 6];
        ld_rec        = '0;
        ld_rec.chan   = req.channel[0];
        ld_rec.op     = req.op;
        ld_rec.count  = req.count;
        ld_rec.status = ST_OK;
        ld_state      = S_PUSH;
        if (bad)
        begin
            ld_rec.status = ST_BAD;
        end
        else if (!cfg.present[dev])
        begin
            ld_rec.status = ST_ABSENT;
        end
        else if (cfg.lba_mode[dev])
        begin
            ld_rec.dh = DH_FIXED | DH_LBA | {3'd0, req.drive[0], req.lba[27:24]};
            ld_rec.b3 = req.lba[7:0];
            ld_rec.b4 = req.lba[15:8];
            ld_rec.b5 = req.lba[23:16];
        end
        else if (h_sel == 5'd0 || s_sel == 6'd0)
        begin
            ld_rec.status = ST_GEOM;
        end
        else
        begin
            ld_rec.dh = DH_FIXED | {3'd0, req.drive[0], 4'd0};
            ld_state  = S_DIV1;
        end
    end

    // four restoring division steps per cycle
    always_comb
    begin
        logic [6:0]  t;
        logic [31:0] q;
        logic [5:0]  r;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < 4; i++)
        begin
            t = {r, q[31]};
            q = {q[30:0], 1'b0};
            if (t >= {1'b0, dvs_reg})
            begin
                t    = t - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
            r = t[5:0];
        end
        quo_next = q;
        rem_next = r;
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ld_state;
                        rec_reg   <= ld_rec;
                        quo_reg   <= req.lba;
                        rem_reg   <= '0;
                        dvs_reg   <= s_sel;
                        heads_reg <= h_sel;
                        cnt_reg   <= '0;
                    end
                end
                S_DIV1:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    quo_reg <= quo_next;
                    if (cnt_reg == 3'd7)
                    begin
                        // sector number, then divide track index by heads
                        rec_reg.b3 <= {2'd0, rem_next} + 8'd1;
                        rem_reg    <= '0;
                        dvs_reg    <= {1'b0, heads_reg};
                        state_reg  <= S_DIV2;
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                    end
                end
                S_DIV2:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    if (cnt_reg == 3'd7)
                    begin
                        rec_reg.b4 <= quo_next[7:0];
                        rec_reg.b5 <= quo_next[15:8];
                        rec_reg.dh <= rec_reg.dh | {4'd0, rem_next[3:0]};
                        state_reg  <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (q_ready)
                    begin
                        if (accept)
                        begin
                            state_reg <= ld_state;
                            rec_reg   <= ld_rec;
                            quo_reg   <= req.lba;
                            rem_reg   <= '0;
                            dvs_reg   <= s_sel;
                            heads_reg <= h_sel;
                            cnt_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/atci_queue.sv =====
// ----------------------------------------------------------------------------
// atci_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module atci_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  atci_pkg::atci_cmd_t push_data,
    output logic                ready,
    output logic                valid,
    output atci_pkg::atci_cmd_t head,
    input  logic                pop
);
    import atci_pkg::*;

    atci_cmd_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign ready   = (fill_reg != 2'd2);
    assign valid   = (fill_reg != 2'd0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/atci_back.sv =====
// ----------------------------------------------------------------------------
// atci_back
// Plays one queued command out as seven port writes, or one error result.
// ----------------------------------------------------------------------------
module atci_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  atci_pkg::atci_cmd_t q_head,
    output logic                q_pop,
    atci_res_if.source          res
);
    import atci_pkg::*;

    atci_cmd_t  cur_reg;
    logic       cur_valid_reg;
    logic [2:0] idx_reg;
    logic       fire;
    logic       is_err;
    logic [9:0] base;

    assign is_err    = (cur_reg.status != ST_OK);
    assign base      = cur_reg.chan ? BASE_SEC : BASE_PRI;
    assign res.valid = cur_valid_reg;
    assign res.last  = is_err || (idx_reg == 3'd6);
    assign res.status = cur_reg.status;
    assign fire      = res.valid && res.ready;
    assign q_pop     = q_valid && (!cur_valid_reg || (fire && res.last));

    // port and byte for the current step
    always_comb
    begin
        res.port  = '0;
        res.value = '0;
        if (!is_err)
        begin
            unique case (idx_reg)
                3'd0:    begin res.port = base + OFS_DH;   res.value = cur_reg.dh;    end
                3'd1:    begin res.port = base + OFS_FEAT; res.value = '0;            end
                3'd2:    begin res.port = base + OFS_CNT;  res.value = cur_reg.count; end
                3'd3:    begin res.port = base + OFS_B3;   res.value = cur_reg.b3;    end
                3'd4:    begin res.port = base + OFS_B4;   res.value = cur_reg.b4;    end
                3'd5:    begin res.port = base + OFS_B5;   res.value = cur_reg.b5;    end
                default:
                begin
                    res.port  = base + OFS_CMD;
                    res.value = cur_reg.op ? CMD_WRITE : CMD_READ;
                end
            endcase
        end
    end

    // step through the command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_reg       <= q_head;
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (fire)
            begin
                if (res.last)
                begin
                    cur_valid_reg <= 1'b0;
                    idx_reg       <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

endmodule

// ===== rtl/ata_taskfile_command_issue.sv =====
// Each request yields seven task-file port writes (drive/head, features,
// count, sector/LBA low, cylinder/LBA mid and high, command) at one per
// cycle while the result channel is ready, or a single error result. LBA28
// and error requests are taken one per cycle at the front while the queue
// has room; a CHS request passes through the front-end divider (two
// divisions, four quotient bits a cycle), and the front end takes no new
// request until the divider is done. A two-entry queue lets the front end
// work on the next request while the back end is still writing ports.
// ----------------------------------------------------------------------------
// ata_taskfile_command_issue
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module ata_taskfile_command_issue #(
    parameter int CHANNELS = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [atci_pkg::CFG_DATA_W-1:0] cfg_data,
    atci_req_if.sink                        req,
    atci_res_if.source                      res
);
    import atci_pkg::*;

    atci_cfg_t cfg_reg;
    atci_cmd_t push_data;
    atci_cmd_t head;
    logic      push;
    logic      q_ready;
    logic      q_valid;
    logic      pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRESENT: cfg_reg.present  <= cfg_data[3:0];
                CFG_LBA:     cfg_reg.lba_mode <= cfg_data[3:0];
                CFG_HEADS:   cfg_reg.heads    <= cfg_data[19:0];
                default:     cfg_reg.sectors  <= cfg_data[23:0];
            endcase
        end
    end

    atci_front #(.CHANNELS(CHANNELS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .req     (req),
        .q_push  (push),
        .q_data  (push_data),
        .q_ready (q_ready)
    );

    atci_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (q_ready),
        .valid     (q_valid),
        .head      (head),
        .pop       (pop)
    );

    atci_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (head),
        .q_pop   (pop),
        .res     (res)
    );

endmodule

// ===== rtl/atci_checker.sv =====
// ----------------------------------------------------------------------------
// atci_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module atci_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_status,
    input logic [9:0] res_port,
    input logic [7:0] res_value,
    input logic       res_last
);
    import atci_pkg::*;

    // an error result is a single transaction carrying zeros
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |-> res_last && res_port == 10'd0
        && res_value == 8'd0)
        else $error("error result not a single zero transaction");

    // the closing write of a command is the command register
    a_cmd_port: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_OK && res_last |->
        (res_port == BASE_PRI + OFS_CMD || res_port == BASE_SEC + OFS_CMD)
        && (res_value == CMD_READ || res_value == CMD_WRITE))
        else $error("last port write is not a command");

    // a command opens with the drive/head write after a last transaction
    a_first_dh: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_last ##1 res_valid && res_status == ST_OK
        |-> res_port == BASE_PRI + OFS_DH || res_port == BASE_SEC + OFS_DH)
        else $error("command does not start with drive/head");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_port)
        && $stable(res_value) && $stable(res_last))
        else $error("stalled result changed");

endmodule

bind ata_taskfile_command_issue atci_checker u_atci_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_status (res.status),
    .res_port   (res.port),
    .res_value  (res.value),
    .res_last   (res.last)
);
